### rtl/core/sca_pkg.sv
package sca_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int RANGE_BITS_DEF = 16;
    localparam int QUEUE_DEPTH    = 4;

    // register indexes, byte address = 4 * index
    localparam logic [2:0] REG_ENABLE     = 3'd0;
    localparam logic [2:0] REG_START      = 3'd1;
    localparam logic [2:0] REG_STEP       = 3'd2;
    localparam logic [2:0] REG_MAX_RANGE  = 3'd3;
    localparam logic [2:0] REG_LOOKAHEAD  = 3'd4;
    localparam logic [2:0] REG_HALF_WIDTH = 3'd5;

    localparam logic [15:0] START_ANGLE_RST = 16'h8000;
    localparam logic [15:0] ANGLE_STEP_RST  = 16'd64;
    localparam logic [15:0] MAX_RANGE_RST   = 16'd30000;
    localparam logic [15:0] LOOKAHEAD_RST   = 16'd1000;
    localparam logic [15:0] HALF_WIDTH_RST  = 16'd350;

    localparam logic [15:0] NONE_GAP = 16'hFFFF;

    // quarter-wave sine polynomial, Q15
    localparam logic [15:0] COEF_A   = 16'd51472;
    localparam logic [14:0] COEF_B   = 15'd21024;
    localparam logic [11:0] COEF_C   = 12'd2320;
    localparam logic [14:0] SINE_MAX = 15'h7FFF;
    localparam logic [15:0] QUARTER  = 16'h8000;

    typedef enum logic [1:0] {
        ACT_PASS  = 2'd0,
        ACT_STOP  = 2'd1,
        ACT_LEFT  = 2'd2,
        ACT_RIGHT = 2'd3
    } action_t;

    typedef struct packed {
        logic        enable;
        logic [15:0] start_angle;
        logic [15:0] angle_step;
        logic [15:0] max_range;
        logic [15:0] lookahead;
        logic [15:0] corridor_hw;
    } cfg_t;

endpackage

### rtl/core/sca_queue.sv
module sca_queue
    import sca_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH    // power of two
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             can_push,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             not_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign can_push  = count_reg != CW'(DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && can_push;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

### rtl/core/sca_front.sv
module sca_front
    import sca_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int RANGE_BITS = RANGE_BITS_DEF,
    parameter int RW         = (RANGE_BITS < 16) ? RANGE_BITS : 16,
    parameter int EW         = RW + ANGLE_BITS + 2
)(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  logic          start_we,
    input  logic [15:0]   start_wr_angle,
    input  logic          in_valid,
    input  logic [15:0]   in_range,
    input  logic          in_last,
    output logic          in_ready,
    output logic          push,
    output logic [EW-1:0] push_data,
    input  logic          can_push
);

    // 16-bit angle to phase: value * 2^ANGLE_BITS / 2^16
    localparam logic [ANGLE_BITS+15:0] RST_WIDE  = {START_ANGLE_RST, {ANGLE_BITS{1'b0}}};
    localparam logic [ANGLE_BITS-1:0]  RST_PHASE = RST_WIDE[ANGLE_BITS+15:16];

    logic [ANGLE_BITS-1:0]  beam_angle_reg;
    logic                   mid_scan_reg;
    logic [ANGLE_BITS+15:0] start_wide;
    logic [ANGLE_BITS+15:0] step_wide;
    logic [ANGLE_BITS+15:0] wr_wide;
    logic [ANGLE_BITS-1:0]  start_phase;
    logic [ANGLE_BITS-1:0]  step_phase;
    logic [ANGLE_BITS-1:0]  wr_phase;
    logic [RW-1:0]          r;
    logic                   sample_ok;
    logic                   accept;

    assign start_wide  = {cfg.start_angle, {ANGLE_BITS{1'b0}}};
    assign step_wide   = {cfg.angle_step, {ANGLE_BITS{1'b0}}};
    assign wr_wide     = {start_wr_angle, {ANGLE_BITS{1'b0}}};
    assign start_phase = start_wide[ANGLE_BITS+15:16];
    assign step_phase  = step_wide[ANGLE_BITS+15:16];
    assign wr_phase    = wr_wide[ANGLE_BITS+15:16];

    assign r         = in_range[RW-1:0];
    assign sample_ok = (r != '0) && (16'(r) <= cfg.max_range);

    assign in_ready  = can_push;
    assign accept    = in_valid && can_push;
    assign push      = accept;
    assign push_data = {r, beam_angle_reg, sample_ok, in_last};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beam_angle_reg <= RST_PHASE;
            mid_scan_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (in_last)
            begin
                beam_angle_reg <= start_phase;
                mid_scan_reg   <= 1'b0;
            end
            else
            begin
                beam_angle_reg <= beam_angle_reg + step_phase;
                mid_scan_reg   <= 1'b1;
            end
        end
        else if (start_we && !mid_scan_reg)
        begin
            beam_angle_reg <= wr_phase;
        end
    end

endmodule

### rtl/core/sca_sine.sv
module sca_sine
    import sca_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [15:0] arg,     // Q15 of a quarter turn, 0..32768
    output logic [14:0] sine
);

    logic [15:0] x1_reg;
    logic [15:0] sq1_reg;
    logic [15:0] x2_reg;
    logic [15:0] sq2_reg;
    logic [14:0] t2_reg;
    logic [15:0] x3_reg;
    logic [15:0] u3_reg;
    logic [14:0] s4_reg;

    logic [31:0] sq_prod;
    logic [27:0] c_prod;
    logic [30:0] u_prod;
    logic [31:0] s_prod;
    logic [16:0] s_full;

    assign sq_prod = 32'(arg) * 32'(arg);
    assign c_prod  = 28'(COEF_C) * 28'(sq1_reg);
    assign u_prod  = 31'(sq2_reg) * 31'(t2_reg);
    assign s_prod  = 32'(x3_reg) * 32'(u3_reg);
    assign s_full  = s_prod[31:15];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg  <= arg;
            sq1_reg <= sq_prod[30:15];
            x2_reg  <= x1_reg;
            sq2_reg <= sq1_reg;
            t2_reg  <= COEF_B - 15'(c_prod[27:15]);
            x3_reg  <= x2_reg;
            u3_reg  <= COEF_A - u_prod[30:15];
            s4_reg  <= (s_full > 17'(SINE_MAX)) ? SINE_MAX : s_full[14:0];
        end
    end

    assign sine = s4_reg;

endmodule

### rtl/core/sca_back.sv
module sca_back
    import sca_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int RANGE_BITS = RANGE_BITS_DEF,
    parameter int RW         = (RANGE_BITS < 16) ? RANGE_BITS : 16,
    parameter int EW         = RW + ANGLE_BITS + 2
)(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  logic [EW-1:0] q_head,
    input  logic          q_not_empty,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [1:0]    out_action,
    output logic [15:0]   out_left,
    output logic [15:0]   out_right
);

    localparam int SD = 4;    // sine unit depth

    logic adv;

    // queue head fields
    logic [RW-1:0]          h_r;
    logic [ANGLE_BITS-1:0]  h_phase;
    logic [ANGLE_BITS+14:0] h_wide;
    logic [14:0]            h_f;

    // stage A: quadrant split
    logic          a_valid_reg;
    logic [RW-1:0] a_r_reg;
    logic          a_ok_reg;
    logic          a_last_reg;
    logic [1:0]    a_q_reg;
    logic [14:0]   a_f_reg;
    logic [15:0]   arg_a;
    logic [15:0]   arg_b;
    logic [14:0]   sine_a;
    logic [14:0]   sine_b;

    // alongside the sine unit
    logic          p_valid_reg [SD];
    logic [RW-1:0] p_r_reg     [SD];
    logic          p_ok_reg    [SD];
    logic          p_last_reg  [SD];
    logic [1:0]    p_q_reg     [SD];

    // stage B: scaled x and y magnitudes
    logic [14:0]      sin_mag;
    logic [14:0]      cos_mag;
    logic [RW+14:0]   x_prod;
    logic [RW+14:0]   y_prod;
    logic             b_valid_reg;
    logic             b_ok_reg;
    logic             b_last_reg;
    logic             b_sin_neg_reg;
    logic             b_cos_neg_reg;
    logic [RW-1:0]    b_xm_reg;
    logic [RW-1:0]    b_ym_reg;

    // stage C: classification
    logic        in_fwd;
    logic [15:0] ym16;
    logic        c_valid_reg;
    logic        c_last_reg;
    logic        c_blk_reg;
    logic        c_left_reg;
    logic        c_right_reg;
    logic [15:0] c_gap_reg;

    // stage D: scan accumulators
    logic        acc_blk_reg;
    logic [15:0] acc_left_reg;
    logic [15:0] acc_right_reg;
    logic        blk_next;
    logic [15:0] left_next;
    logic [15:0] right_next;
    logic        fin_valid_reg;
    logic        fin_blk_reg;
    logic [15:0] fin_left_reg;
    logic [15:0] fin_right_reg;

    // stage E: decision
    logic        lok;
    logic        rok;
    action_t     action;
    logic        out_valid_reg;
    logic [1:0]  out_action_reg;
    logic [15:0] out_left_reg;
    logic [15:0] out_right_reg;

    // whole back end moves together; stalls only on a held result word
    assign adv   = !out_valid_reg || out_ready;
    assign q_pop = adv && q_not_empty;

    assign h_r     = q_head[EW-1 -: RW];
    assign h_phase = q_head[ANGLE_BITS+1:2];
    assign h_wide  = {h_phase[ANGLE_BITS-3:0], 17'd0};
    assign h_f     = h_wide[ANGLE_BITS+14:ANGLE_BITS];

    assign arg_a = {1'b0, a_f_reg};
    assign arg_b = QUARTER - {1'b0, a_f_reg};

    sca_sine u_sine_a (
        .clk  (clk),
        .en   (adv),
        .arg  (arg_a),
        .sine (sine_a)
    );

    sca_sine u_sine_b (
        .clk  (clk),
        .en   (adv),
        .arg  (arg_b),
        .sine (sine_b)
    );

    assign sin_mag = p_q_reg[SD-1][0] ? sine_b : sine_a;
    assign cos_mag = p_q_reg[SD-1][0] ? sine_a : sine_b;
    assign x_prod  = (RW+15)'(p_r_reg[SD-1]) * (RW+15)'(cos_mag);
    assign y_prod  = (RW+15)'(p_r_reg[SD-1]) * (RW+15)'(sin_mag);

    assign ym16   = 16'(b_ym_reg);
    assign in_fwd = b_ok_reg && !b_cos_neg_reg && (b_xm_reg != '0)
                    && (16'(b_xm_reg) <= cfg.lookahead);

    assign blk_next   = acc_blk_reg || c_blk_reg;
    assign left_next  = (c_left_reg && (c_gap_reg < acc_left_reg)) ? c_gap_reg : acc_left_reg;
    assign right_next = (c_right_reg && (c_gap_reg < acc_right_reg)) ? c_gap_reg
                                                                    : acc_right_reg;

    assign lok = (fin_left_reg == NONE_GAP) || (fin_left_reg > cfg.lookahead);
    assign rok = (fin_right_reg == NONE_GAP) || (fin_right_reg > cfg.lookahead);

    always_comb
    begin
        if (!cfg.enable || !fin_blk_reg)
        begin
            action = ACT_PASS;
        end
        else if (!lok && !rok)
        begin
            action = ACT_STOP;
        end
        else if (lok && (!rok || (fin_left_reg >= fin_right_reg)))
        begin
            action = ACT_LEFT;
        end
        else
        begin
            action = ACT_RIGHT;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_r_reg    <= h_r;
            a_ok_reg   <= q_head[1];
            a_last_reg <= q_head[0];
            a_q_reg    <= h_phase[ANGLE_BITS-1 -: 2];
            a_f_reg    <= h_f;

            p_r_reg[0]    <= a_r_reg;
            p_ok_reg[0]   <= a_ok_reg;
            p_last_reg[0] <= a_last_reg;
            p_q_reg[0]    <= a_q_reg;
            for (int i = 1; i < SD; i++)
            begin
                p_r_reg[i]    <= p_r_reg[i-1];
                p_ok_reg[i]   <= p_ok_reg[i-1];
                p_last_reg[i] <= p_last_reg[i-1];
                p_q_reg[i]    <= p_q_reg[i-1];
            end

            b_ok_reg      <= p_ok_reg[SD-1];
            b_last_reg    <= p_last_reg[SD-1];
            b_sin_neg_reg <= p_q_reg[SD-1][1];
            b_cos_neg_reg <= p_q_reg[SD-1][1] ^ p_q_reg[SD-1][0];
            b_xm_reg      <= x_prod[RW+14:15];
            b_ym_reg      <= y_prod[RW+14:15];

            c_last_reg  <= b_last_reg;
            c_blk_reg   <= in_fwd && (ym16 <= cfg.corridor_hw);
            c_left_reg  <= in_fwd && (ym16 > cfg.corridor_hw) && !b_sin_neg_reg;
            c_right_reg <= in_fwd && (ym16 > cfg.corridor_hw) && b_sin_neg_reg;
            c_gap_reg   <= ym16 - cfg.corridor_hw;

            if (c_valid_reg && c_last_reg)
            begin
                fin_blk_reg   <= blk_next;
                fin_left_reg  <= left_next;
                fin_right_reg <= right_next;
            end

            out_action_reg <= action;
            out_left_reg   <= fin_left_reg;
            out_right_reg  <= fin_right_reg;
        end
    end

    // valids and scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            for (int i = 0; i < SD; i++)
            begin
                p_valid_reg[i] <= 1'b0;
            end
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_blk_reg   <= 1'b0;
            acc_left_reg  <= NONE_GAP;
            acc_right_reg <= NONE_GAP;
        end
        else if (adv)
        begin
            a_valid_reg    <= q_not_empty;
            p_valid_reg[0] <= a_valid_reg;
            for (int i = 1; i < SD; i++)
            begin
                p_valid_reg[i] <= p_valid_reg[i-1];
            end
            b_valid_reg   <= p_valid_reg[SD-1];
            c_valid_reg   <= b_valid_reg;
            fin_valid_reg <= c_valid_reg && c_last_reg;
            out_valid_reg <= fin_valid_reg;
            if (c_valid_reg)
            begin
                if (c_last_reg)
                begin
                    acc_blk_reg   <= 1'b0;
                    acc_left_reg  <= NONE_GAP;
                    acc_right_reg <= NONE_GAP;
                end
                else
                begin
                    acc_blk_reg   <= blk_next;
                    acc_left_reg  <= left_next;
                    acc_right_reg <= right_next;
                end
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_action = out_action_reg;
    assign out_left   = out_left_reg;
    assign out_right  = out_right_reg;

endmodule

### rtl/core/scan_corridor_avoidance.sv
// Forward-corridor obstacle check over one lidar scan.
// Input stream (s_*): one range sample per word, s_tlast on the final beam
// of a scan. Output stream (m_*): one decision word per scan, sent after
// the word carrying s_tlast; other samples produce no output.
// Configuration over the APB port, registers at byte address 4*index:
// enable, start_angle, angle_step, max_range_mm, lookahead_mm, half_width_mm.
// Write configuration only while no scan is in flight.
// Throughput: one sample word per cycle while no decision word is held back.
// m_tvalid rises once the s_tlast word has passed the back-end pipeline:
// queue read, quadrant split, two 4-stage sine polynomial units, range
// scaling multiply, classify, accumulate and decision stages.
// Reset clears the scan state and loads the register defaults; the first
// beam angle comes from start_angle.
// When a decision word waits on a low m_tready the back end holds; a 4-word
// queue behind the input keeps taking samples; s_tready drops only when full.
module scan_corridor_avoidance
    import sca_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int RANGE_BITS = RANGE_BITS_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] range_mm
    input  logic        s_tlast,    // last_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [1:0] action, [17:2] left_clearance_mm,
                                    // [33:18] right_clearance_mm, rest zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int RW = (RANGE_BITS < 16) ? RANGE_BITS : 16;
    localparam int EW = RW + ANGLE_BITS + 2;

    cfg_t          cfg_reg;
    logic          cfg_wr;
    logic [2:0]    cfg_idx;
    logic          start_we;
    logic          push;
    logic [EW-1:0] push_data;
    logic          can_push;
    logic          pop;
    logic [EW-1:0] head;
    logic          not_empty;
    logic [1:0]    action;
    logic [15:0]   left_clear;
    logic [15:0]   right_clear;

    assign pready   = 1'b1;
    assign cfg_idx  = paddr[4:2];
    assign cfg_wr   = psel && penable && pwrite;
    assign start_we = cfg_wr && (cfg_idx == REG_START);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable      <= 1'b0;
            cfg_reg.start_angle <= START_ANGLE_RST;
            cfg_reg.angle_step  <= ANGLE_STEP_RST;
            cfg_reg.max_range   <= MAX_RANGE_RST;
            cfg_reg.lookahead   <= LOOKAHEAD_RST;
            cfg_reg.corridor_hw <= HALF_WIDTH_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_ENABLE:     cfg_reg.enable      <= pwdata[0];
                REG_START:      cfg_reg.start_angle <= pwdata[15:0];
                REG_STEP:       cfg_reg.angle_step  <= pwdata[15:0];
                REG_MAX_RANGE:  cfg_reg.max_range   <= pwdata[15:0];
                REG_LOOKAHEAD:  cfg_reg.lookahead   <= pwdata[15:0];
                REG_HALF_WIDTH: cfg_reg.corridor_hw <= pwdata[15:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_ENABLE:     prdata = {31'd0, cfg_reg.enable};
            REG_START:      prdata = {16'd0, cfg_reg.start_angle};
            REG_STEP:       prdata = {16'd0, cfg_reg.angle_step};
            REG_MAX_RANGE:  prdata = {16'd0, cfg_reg.max_range};
            REG_LOOKAHEAD:  prdata = {16'd0, cfg_reg.lookahead};
            REG_HALF_WIDTH: prdata = {16'd0, cfg_reg.corridor_hw};
            default:        prdata = 32'd0;
        endcase
    end

    sca_front #(
        .ANGLE_BITS (ANGLE_BITS),
        .RANGE_BITS (RANGE_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .start_we       (start_we),
        .start_wr_angle (pwdata[15:0]),
        .in_valid       (s_tvalid),
        .in_range       (s_tdata),
        .in_last        (s_tlast),
        .in_ready       (s_tready),
        .push           (push),
        .push_data      (push_data),
        .can_push       (can_push)
    );

    sca_queue #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .can_push  (can_push),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty)
    );

    sca_back #(
        .ANGLE_BITS (ANGLE_BITS),
        .RANGE_BITS (RANGE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_head      (head),
        .q_not_empty (not_empty),
        .q_pop       (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_action  (action),
        .out_left    (left_clear),
        .out_right   (right_clear)
    );

    assign m_tdata = {6'd0, right_clear, left_clear, action};

endmodule

### tb/scan_decision_checker.sv
module scan_decision_checker
    import sca_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          errors,
    output int          pending
);

    typedef struct {
        action_t     act;
        logic [15:0] left_clear;
        logic [15:0] right_clear;
    } decision_t;

    decision_t   decisions_due[$];
    cfg_t        cfg;
    logic [15:0] beam_phase;
    logic        blocked;
    logic [15:0] left_min;
    logic [15:0] right_min;
    logic        in_scan;
    int          err_count;

    // quarter-wave sine polynomial, f in Q15 of a quarter turn
    function automatic longint quarter_sine(input longint f);
        longint ca, cb, cc, f2, t, t2, s;
        ca = COEF_A;
        cb = COEF_B;
        cc = COEF_C;
        f2 = (f * f) >>> 15;
        t  = cb - ((cc * f2) >>> 15);
        t2 = ca - ((f2 * t) >>> 15);
        s  = (f * t2) >>> 15;
        if (s > 32767)
            s = 32767;
        return s;
    endfunction

    // r * trig / 32768, truncated toward zero
    function automatic longint project(input longint r, input longint t);
        longint p;
        p = r * t;
        if (p >= 0)
            return p >>> 15;
        return -((-p) >>> 15);
    endfunction

    task automatic clear_scan();
        beam_phase = cfg.start_angle;
        blocked    = 1'b0;
        left_min   = NONE_GAP;
        right_min  = NONE_GAP;
        in_scan    = 1'b0;
    endtask

    task automatic take_sample(input logic [15:0] r, input logic last);
        logic [15:0] phase;
        longint      f, a, b, sn, cs, x, y, ay, hw, lk, g;
        logic        lok, rok;
        decision_t   d;
        phase      = beam_phase;
        in_scan    = 1'b1;
        beam_phase = beam_phase + cfg.angle_step;
        hw = cfg.corridor_hw;
        lk = cfg.lookahead;
        if (r != 16'd0 && r <= cfg.max_range)
        begin
            f = {phase[13:0], 1'b0};
            a = quarter_sine(f);
            b = quarter_sine(32768 - f);
            case (phase[15:14])
                2'd0:    begin sn = a;  cs = b;  end
                2'd1:    begin sn = b;  cs = -a; end
                2'd2:    begin sn = -a; cs = -b; end
                default: begin sn = -b; cs = a;  end
            endcase
            x  = project(r, cs);
            y  = project(r, sn);
            ay = (y < 0) ? -y : y;
            if (x > 0 && x <= lk)
            begin
                if (ay <= hw)
                    blocked = 1'b1;
                else if (y > 0)
                begin
                    g = y - hw;
                    if (g < longint'(left_min))
                        left_min = g[15:0];
                end
                else
                begin
                    g = -y - hw;
                    if (g < longint'(right_min))
                        right_min = g[15:0];
                end
            end
        end
        if (last)
        begin
            d.act = ACT_PASS;
            if (cfg.enable && blocked)
            begin
                lok = (left_min == NONE_GAP) || (left_min > cfg.lookahead);
                rok = (right_min == NONE_GAP) || (right_min > cfg.lookahead);
                if (!lok && !rok)
                    d.act = ACT_STOP;
                else if (lok && (!rok || left_min >= right_min))
                    d.act = ACT_LEFT;
                else
                    d.act = ACT_RIGHT;
            end
            d.left_clear  = left_min;
            d.right_clear = right_min;
            decisions_due.push_back(d);
            clear_scan();
        end
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [31:0] val);
        case (idx)
            REG_ENABLE:     cfg.enable     = val[0];
            REG_START:
            begin
                cfg.start_angle = val[15:0];
                if (!in_scan)
                    beam_phase = val[15:0];
            end
            REG_STEP:       cfg.angle_step  = val[15:0];
            REG_MAX_RANGE:  cfg.max_range   = val[15:0];
            REG_LOOKAHEAD:  cfg.lookahead   = val[15:0];
            REG_HALF_WIDTH: cfg.corridor_hw = val[15:0];
            default: ;
        endcase
    endtask

    task automatic check_decision(input logic [39:0] word);
        decision_t d;
        if (decisions_due.size() == 0)
        begin
            $error("decision word with none pending: %h", word);
            err_count++;
        end
        else
        begin
            d = decisions_due.pop_front();
            if (word[1:0] !== d.act)
            begin
                $error("action: expected %0d, got %0d", d.act, word[1:0]);
                err_count++;
            end
            if (word[17:2] !== d.left_clear)
            begin
                $error("left_clearance_mm: expected %0d, got %0d",
                       d.left_clear, word[17:2]);
                err_count++;
            end
            if (word[33:18] !== d.right_clear)
            begin
                $error("right_clearance_mm: expected %0d, got %0d",
                       d.right_clear, word[33:18]);
                err_count++;
            end
            if (word[39:34] !== 6'd0)
            begin
                $error("padding: expected 0, got %0d", word[39:34]);
                err_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.enable      = 1'b0;
            cfg.start_angle = START_ANGLE_RST;
            cfg.angle_step  = ANGLE_STEP_RST;
            cfg.max_range   = MAX_RANGE_RST;
            cfg.lookahead   = LOOKAHEAD_RST;
            cfg.corridor_hw = HALF_WIDTH_RST;
            clear_scan();
            decisions_due.delete();
            err_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
                write_register(paddr[4:2], pwdata);
            if (s_tvalid && s_tready)
                take_sample(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                check_decision(m_tdata);
        end
        errors  <= err_count;
        pending <= decisions_due.size();
    end

endmodule

### tb/scan_corridor_avoidance_test.sv
module scan_corridor_avoidance_test;
    import sca_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = 16'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = 5'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    int          errors;
    int          pending;
    int          cycle_count = 0;
    logic        calm = 1'b0;
    logic [15:0] cur_max;

    scan_corridor_avoidance uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    scan_decision_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .pready   (pready),
        .errors   (errors),
        .pending  (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(negedge clk)
        m_tready = calm || ($urandom_range(99) >= 6);

    task automatic push_sample(input logic [15:0] r, input logic last);
        while (!calm && $urandom_range(99) < 6)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = r;
        s_tlast  = last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // wait for the last decision, then for the back end to empty
    task automatic drain_decisions();
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_config(input logic en, input logic [15:0] start,
                              input logic [15:0] step, input logic [15:0] maxr,
                              input logic [15:0] look, input logic [15:0] hw);
        drain_decisions();
        write_reg(REG_ENABLE, {31'd0, en});
        write_reg(REG_START, {16'd0, start});
        write_reg(REG_STEP, {16'd0, step});
        write_reg(REG_MAX_RANGE, {16'd0, maxr});
        write_reg(REG_LOOKAHEAD, {16'd0, look});
        write_reg(REG_HALF_WIDTH, {16'd0, hw});
        cur_max = maxr;
    endtask

    function automatic logic [15:0] pick_range(input logic [15:0] limit);
        int roll;
        roll = $urandom_range(99);
        if (roll < 5)
            return 16'd0;
        if (roll < 10)
            return (limit == 16'hFFFF) ? 16'hFFFF : limit + 16'd1;
        if (roll < 14)
            return 16'hFFFF;
        if (roll < 22)
            return 16'($urandom());
        return 16'($urandom_range(1, 1600));
    endfunction

    initial
    begin
        int phase_items;
        int len;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // beams at -22.5, -11.25 and 0 degrees
        set_config(1'b1, 16'hF000, 16'h0800, 16'd5000, 16'd1000, 16'd350);
        push_sample(16'd0, 1'b1);
        push_sample(16'd5001, 1'b1);
        push_sample(16'd5000, 1'b1);
        push_sample(16'd1, 1'b1);
        push_sample(16'hFFFF, 1'b1);
        push_sample(16'd1000, 1'b0);
        push_sample(16'd500, 1'b0);
        push_sample(16'd1000, 1'b1);
        push_sample(16'd1000, 1'b0);
        push_sample(16'd500, 1'b0);
        push_sample(16'd0, 1'b1);
        push_sample(16'd0, 1'b0);
        push_sample(16'd500, 1'b0);
        push_sample(16'd1000, 1'b1);
        // blocked with no side gaps at all: tie goes left
        push_sample(16'd0, 1'b0);
        push_sample(16'd500, 1'b0);
        push_sample(16'd0, 1'b1);
        set_config(1'b0, 16'hF000, 16'h0800, 16'd5000, 16'd1000, 16'd350);
        push_sample(16'd1000, 1'b0);
        push_sample(16'd500, 1'b0);
        push_sample(16'd1000, 1'b1);

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: set_config(1'b1, 16'hF000, 16'd512, 16'd3000, 16'd1000, 16'd350);
                1: set_config(1'b1, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                              16'($urandom()), 16'($urandom()));
                2: set_config(1'b1, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF, 16'd0);
                3: set_config(1'b1, 16'h8000, 16'h7FFF, 16'd0, 16'd0, 16'hFFFF);
                4: set_config(1'b0, 16'hF000, 16'd512, 16'd3000, 16'd1000, 16'd350);
                5: set_config(1'b1, 16'hE000, 16'd256, 16'd4000, 16'd2000, 16'd50);
                6: set_config(1'b1, 16'($urandom_range(65535)), 16'($urandom_range(2048)),
                              16'($urandom_range(65535)), 16'($urandom_range(3000)),
                              16'($urandom_range(800)));
                default:
                begin
                    set_config(1'b1, 16'hF800, 16'd384, 16'd2500, 16'd800, 16'd300);
                    calm = 1'b1;
                end
            endcase
            phase_items = 0;
            while (phase_items < 50)
            begin
                len = $urandom_range(1, 16);
                for (int k = 0; k < len; k++)
                    push_sample(pick_range(cur_max), k == len - 1);
                phase_items += len;
            end
        end

        drain_decisions();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### scan_corridor_avoidance.f
rtl/core/sca_pkg.sv
rtl/core/sca_queue.sv
rtl/core/sca_front.sv
rtl/core/sca_sine.sv
rtl/core/sca_back.sv
rtl/core/scan_corridor_avoidance.sv
tb/scan_decision_checker.sv
tb/scan_corridor_avoidance_test.sv
